[src/scl_pkg.sv]
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and codes for the snooping coherence line controller.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int ADDR_W = 16;
  localparam int LEN_W  = 7;
  localparam int ACT_W  = 3;

  localparam logic [ACT_W-1:0] ACT_CPU_RD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CPU_WR   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SNP_RD   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SNP_RDX  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SNP_UPD  = 3'd4;

  localparam logic [0:0] REG_PROTOCOL_MODE = 1'b0;

  typedef enum logic [1:0] {
    ST_INVALID  = 2'd0,
    ST_SHARED   = 2'd1,
    ST_MODIFIED = 2'd2
  } line_state_t;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_RDX  = 2'd2,
    BUS_UPD  = 2'd3
  } bus_req_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    bus_req_t    bus_request;
    line_state_t prior_state;
    line_state_t next_state;
  } eval_res_t;

endpackage

[src/scl_state_mem.sv]
// ----------------------------------------------------------------------------
// scl_state_mem
// Per-line coherence state memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module scl_state_mem #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  output logic                      clr_busy,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_idx,
  output scl_pkg::line_state_t      rd_state,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  scl_pkg::line_state_t      wr_state
);
  import scl_pkg::*;

  line_state_t      mem [DEPTH];
  line_state_t      rd_state_r;
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= ST_INVALID;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_state;
    end
    if (rd_en) begin
      rd_state_r <= mem[rd_idx];
    end
  end

  assign clr_busy = clr_busy_r;
  assign rd_state = rd_state_r;

endmodule

[src/scl_line_eval.sv]
// ----------------------------------------------------------------------------
// scl_line_eval
// Coherence transition logic: status, hit, bus request and next line state.
// ----------------------------------------------------------------------------
module scl_line_eval (
  input  logic [scl_pkg::ACT_W-1:0] action,
  input  logic                      burst_err,
  input  scl_pkg::line_state_t      prior,
  input  logic                      firefly,
  output scl_pkg::eval_res_t        res
);
  import scl_pkg::*;

  logic hit;

  assign hit = (prior == ST_SHARED) || (prior == ST_MODIFIED);

  always_comb begin
    res             = '0;
    res.prior_state = prior;
    res.next_state  = prior;
    res.hit         = hit;
    res.bus_request = BUS_NONE;
    case (action)
      ACT_CPU_RD, ACT_CPU_WR: begin
        if (burst_err) begin
          res.status = 1'b1;
          res.hit    = 1'b0;
        end else if (hit) begin
          if (action == ACT_CPU_WR && prior == ST_SHARED) begin
            if (firefly) begin
              res.bus_request = BUS_UPD;
            end else begin
              res.bus_request = BUS_RDX;
              res.next_state  = ST_MODIFIED;
            end
          end
        end else if (action == ACT_CPU_WR) begin
          res.bus_request = BUS_RDX;
          res.next_state  = ST_MODIFIED;
        end else begin
          res.bus_request = BUS_RD;
          res.next_state  = ST_SHARED;
        end
      end
      ACT_SNP_RD: begin
        if (prior == ST_MODIFIED) res.next_state = ST_SHARED;
      end
      ACT_SNP_RDX: begin
        if (hit) res.next_state = ST_INVALID;
      end
      ACT_SNP_UPD: begin
        if (firefly && prior == ST_MODIFIED) res.next_state = ST_SHARED;
      end
      default: begin
      end
    endcase
  end

endmodule

[src/snooping_coherence_line_controller.sv]
// ----------------------------------------------------------------------------
// snooping_coherence_line_controller
// MSI / Firefly snooping coherence state tracker, one state per memory line.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per CPU read/write or snooped BusRd/BusRdX/BusUpd.
//   out_* : one result transaction per input: status, hit, bus request and
//           the line state before and after.
//   cfg_* : APB register protocol_mode at byte address 0 (0 MSI, 1 Firefly).
// Throughput is one transaction per cycle unless a low out_tready holds
// the pipeline; the state memory is read at acceptance, then the
// transition is evaluated and registered into the result register.
// A transaction to the line written by the one ahead of it takes the new
// state from a forwarding register.
// After reset the state memory is swept to Invalid, one line per cycle, over
// all MEMORY_LINES lines; in_tready stays low during the sweep.
// When out_tready is low the result register and the stage ahead of it hold
// and in_tready drops once both are full.
// LINE_BYTES and MEMORY_LINES are powers of two.
// ----------------------------------------------------------------------------
module snooping_coherence_line_controller #(
  parameter int LINE_BYTES   = 64,
  parameter int MEMORY_LINES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] action, [18:3] byte_address, [25:19] access_length
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] status, [1] hit, [3:2] bus_request, [5:4] prior_state, [7:6] next_state
  output logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import scl_pkg::*;

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int IDX_W = (MEMORY_LINES > 1) ? $clog2(MEMORY_LINES) : 1;
  localparam int SUM_W = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;

  logic [ACT_W-1:0]  in_action;
  logic [ADDR_W-1:0] in_byte_address;
  logic [LEN_W-1:0]  in_access_length;
  logic [ADDR_W-1:0] in_line_num;
  logic [IDX_W-1:0]  in_idx;
  logic              in_acc;

  logic              mode_r;
  logic              s1_v_r;
  logic [ACT_W-1:0]  s1_action_r;
  logic [OFF_W-1:0]  s1_offset_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              fwd_r;
  line_state_t       fwd_state_r;
  logic              out_v_r;
  eval_res_t         out_res_r;

  logic              clr_busy;
  line_state_t       rd_state;
  line_state_t       prior;
  logic              s1_adv;
  logic              s1_wr;
  logic [SUM_W-1:0]  end_pos;
  logic              burst_err;
  eval_res_t         res;
  logic              cfg_wr;

  assign in_action        = in_tdata[2:0];
  assign in_byte_address  = in_tdata[18:3];
  assign in_access_length = in_tdata[25:19];
  assign in_line_num      = in_byte_address >> OFF_W;
  assign in_idx           = in_line_num[IDX_W-1:0];

  assign s1_adv    = !out_v_r || out_tready;
  assign s1_wr     = s1_v_r && s1_adv;
  assign in_tready = !clr_busy && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_PROTOCOL_MODE) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == REG_PROTOCOL_MODE) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  scl_state_mem #(
    .DEPTH (MEMORY_LINES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy),
    .rd_en    (in_acc),
    .rd_idx   (in_idx),
    .rd_state (rd_state),
    .wr_en    (s1_wr),
    .wr_idx   (s1_idx_r),
    .wr_state (res.next_state)
  );

  assign prior     = fwd_r ? fwd_state_r : rd_state;
  assign end_pos   = SUM_W'(s1_offset_r) + SUM_W'(s1_len_r);
  assign burst_err = (s1_len_r != '0) && (end_pos > SUM_W'(LINE_BYTES));

  scl_line_eval u_eval (
    .action    (s1_action_r),
    .burst_err (burst_err),
    .prior     (prior),
    .firefly   (mode_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_offset_r <= in_byte_address[OFF_W-1:0];
      s1_len_r    <= in_access_length;
      s1_idx_r    <= in_idx;
      fwd_r       <= s1_wr && (s1_idx_r == in_idx);
      fwd_state_r <= res.next_state;
    end
    if (s1_wr) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.next_state, out_res_r.prior_state,
                       out_res_r.bus_request, out_res_r.hit, out_res_r.status};

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the snooping coherence line controller. A directed
// pass walks CPU and snoop transitions under MSI and Firefly, burst
// errors, zero-length accesses, the last line and the unused action codes.
// Random passes follow, mostly on a small pool of hot lines. Each accepted
// transaction is run through a line-state mirror in the bench. Every result
// is compared field by field with the oldest outstanding prediction, while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scl_pkg::*;

  localparam int LINE_BYTES   = 64;
  localparam int MEMORY_LINES = 1024;
  localparam int HOT_LINES    = 16;
  localparam int MAX_WAIT     = 13;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SHOW_LIMIT   = 10;

  localparam logic MODE_MSI     = 1'b0;
  localparam logic MODE_FIREFLY = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic [ACT_W-1:0]  act;
  } access_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  snooping_coherence_line_controller #(
    .LINE_BYTES  (LINE_BYTES),
    .MEMORY_LINES(MEMORY_LINES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  line_state_t line_mirror [MEMORY_LINES];
  logic        mode_mirror = MODE_MSI;
  access_t     access_queue [$];
  eval_res_t   pending_outcomes [$];
  int unsigned hot_line [HOT_LINES];

  access_t     cur_access;
  logic        nxt_valid;
  logic        in_calm   = 1'b0;
  logic        out_calm  = 1'b0;
  int          in_gap    = 0;
  int          out_hold  = 0;
  int          queued    = 0;
  int          accepted  = 0;
  int          checked   = 0;
  int          errors    = 0;
  int          cycles    = 0;
  int          n_cpu_rd  = 0;
  int          n_cpu_wr  = 0;
  int          n_snoop   = 0;
  int          n_unused  = 0;
  int          n_burst   = 0;
  int          n_busreq  = 0;
  int          n_modes   = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic eval_res_t coherence_outcome(input access_t a);
    int unsigned idx;
    int unsigned offs;
    eval_res_t   r;
    idx  = (int'(a.addr) / LINE_BYTES) % MEMORY_LINES;
    offs = int'(a.addr) % LINE_BYTES;
    r.status      = 1'b0;
    r.prior_state = line_mirror[idx];
    r.next_state  = r.prior_state;
    r.bus_request = BUS_NONE;
    r.hit = (r.prior_state == ST_SHARED) || (r.prior_state == ST_MODIFIED);
    case (a.act)
      ACT_CPU_RD, ACT_CPU_WR: begin
        if (a.len != 0 && offs + int'(a.len) > LINE_BYTES) begin
          r.status = 1'b1;
          r.hit    = 1'b0;
        end else if (r.hit) begin
          if (a.act == ACT_CPU_WR && r.prior_state == ST_SHARED) begin
            if (mode_mirror == MODE_FIREFLY) begin
              r.bus_request = BUS_UPD;
            end else begin
              r.bus_request = BUS_RDX;
              r.next_state  = ST_MODIFIED;
            end
          end
        end else if (a.act == ACT_CPU_WR) begin
          r.bus_request = BUS_RDX;
          r.next_state  = ST_MODIFIED;
        end else begin
          r.bus_request = BUS_RD;
          r.next_state  = ST_SHARED;
        end
      end
      ACT_SNP_RD: begin
        if (r.prior_state == ST_MODIFIED) r.next_state = ST_SHARED;
      end
      ACT_SNP_RDX: begin
        if (r.hit) r.next_state = ST_INVALID;
      end
      ACT_SNP_UPD: begin
        if (mode_mirror == MODE_FIREFLY && r.prior_state == ST_MODIFIED)
          r.next_state = ST_SHARED;
      end
      default: ;
    endcase
    line_mirror[idx] = r.next_state;
    return r;
  endfunction

  function automatic int draw_wait(input logic calm);
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        pending_outcomes.push_back(coherence_outcome(cur_access));
        accepted++;
        case (cur_access.act)
          ACT_CPU_RD:                           n_cpu_rd++;
          ACT_CPU_WR:                           n_cpu_wr++;
          ACT_SNP_RD, ACT_SNP_RDX, ACT_SNP_UPD: n_snoop++;
          default:                              n_unused++;
        endcase
        if (pending_outcomes[$].status) n_burst++;
        if (pending_outcomes[$].bus_request != BUS_NONE) n_busreq++;
        nxt_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
        in_gap = draw_wait(in_calm);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (access_queue.size() != 0) begin
          cur_access = access_queue.pop_front();
          in_tdata  <= {6'b0, cur_access};
          nxt_valid  = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    eval_res_t want;
    eval_res_t seen;
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.status      = out_tdata[0];
        seen.hit         = out_tdata[1];
        seen.bus_request = bus_req_t'(out_tdata[3:2]);
        seen.prior_state = line_state_t'(out_tdata[5:4]);
        seen.next_state  = line_state_t'(out_tdata[7:6]);
        if (pending_outcomes.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("%0t: result with nothing outstanding: data %h", $realtime, out_tdata);
        end else begin
          want = pending_outcomes.pop_front();
          checked++;
          if (seen !== want) begin
            errors++;
            if (errors <= SHOW_LIMIT)
              $display({"%0t: mismatch on result %0d: status %b/%b hit %b/%b ",
                        "bus %0d/%0d prior %0d/%0d next %0d/%0d (expected/actual)"},
                       $realtime, checked, want.status, seen.status, want.hit, seen.hit,
                       want.bus_request, seen.bus_request, want.prior_state,
                       seen.prior_state, want.next_state, seen.next_state);
          end
        end
        if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
        out_hold = draw_wait(out_calm);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_tready <= (out_hold == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $realtime,
               pending_outcomes.size());
      $display("snooping_coherence_line_controller test failed");
      $finish;
    end
  end

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * REG_PROTOCOL_MODE);
    cfg_pwdata  <= {31'b0, mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    mode_mirror = mode;
    n_modes++;
  endtask

  task automatic queue_access(input logic [ACT_W-1:0] act, input int addr, input int len);
    access_t a;
    a.act  = act;
    a.addr = ADDR_W'(addr);
    a.len  = LEN_W'(len);
    access_queue.push_back(a);
    queued++;
  endtask

  task automatic queue_random(input int count);
    int unsigned r;
    int unsigned offs;
    int          addr;
    int          len;
    logic [ACT_W-1:0] act;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if      (r < 30) act = ACT_CPU_RD;
      else if (r < 55) act = ACT_CPU_WR;
      else if (r < 68) act = ACT_SNP_RD;
      else if (r < 80) act = ACT_SNP_RDX;
      else if (r < 92) act = ACT_SNP_UPD;
      else             act = ACT_W'($urandom_range(5, 7));
      if ($urandom_range(0, 9) < 7) begin
        offs = $urandom_range(0, LINE_BYTES - 1);
        addr = int'(hot_line[$urandom_range(0, HOT_LINES - 1)]) * LINE_BYTES + int'(offs);
      end else begin
        addr = $urandom_range(0, 65535);
        offs = addr % LINE_BYTES;
      end
      r = $urandom_range(0, 99);
      if      (r < 60) len = $urandom_range(1, LINE_BYTES - offs);
      else if (r < 72) len = 0;
      else             len = $urandom_range(0, 127);
      queue_access(act, addr, len);
    end
  endtask

  task automatic drain();
    while (accepted != queued || pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    foreach (line_mirror[i]) line_mirror[i] = ST_INVALID;
    hot_line[0] = 0;
    hot_line[1] = MEMORY_LINES - 1;
    for (int i = 2; i < HOT_LINES; i++) hot_line[i] = $urandom_range(0, MEMORY_LINES - 1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_MSI);
    queue_access(ACT_CPU_RD,  16'h0000, 1);
    queue_access(ACT_CPU_RD,  16'h0000, 64);
    queue_access(ACT_CPU_WR,  16'h0010, 0);
    queue_access(ACT_CPU_WR,  16'h0000, 4);
    queue_access(ACT_SNP_UPD, 16'h0000, 0);
    queue_access(ACT_SNP_RD,  16'h003F, 0);
    queue_access(ACT_SNP_RDX, 16'h0000, 0);
    queue_access(ACT_CPU_WR,  16'hFFFF, 1);
    queue_access(ACT_CPU_RD,  16'hFFFF, 2);
    queue_access(ACT_CPU_RD,  16'hFFC0, 127);
    queue_access(3'd5,        16'hFFFF, 127);
    queue_access(3'd7,        16'h0000, 0);
    queue_access(ACT_SNP_RDX, 16'hFFFF, 0);
    queue_access(ACT_CPU_WR,  16'h1234, 127);
    drain();

    write_mode(MODE_FIREFLY);
    queue_access(ACT_CPU_RD,  16'h0040, 8);
    queue_access(ACT_CPU_WR,  16'h0040, 8);
    queue_access(ACT_SNP_UPD, 16'h0040, 0);
    queue_access(ACT_SNP_RDX, 16'h0040, 0);
    queue_access(ACT_CPU_WR,  16'h0080, 64);
    queue_access(ACT_SNP_UPD, 16'h0080, 0);
    queue_access(ACT_CPU_WR,  16'h0080, 1);
    queue_access(ACT_SNP_RD,  16'h0100, 0);
    queue_access(3'd6,        16'h8000, 85);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_mode((p % 2 == 0) ? MODE_MSI : MODE_FIREFLY);
      queue_random(317);
      drain();
    end

    repeat (8) @(posedge clk);
    if (pending_outcomes.size() != 0) errors++;
    $display("covered %0d transactions: %0d cpu reads, %0d cpu writes, %0d snoops, %0d unused codes",
             accepted, n_cpu_rd, n_cpu_wr, n_snoop, n_unused);
    $display("%0d results checked, %0d burst errors, %0d bus requests, %0d mode writes, %0d mismatches",
             checked, n_burst, n_busreq, n_modes, errors);
    if (errors == 0) begin
      $display("snooping_coherence_line_controller test passed");
    end else begin
      $display("snooping_coherence_line_controller test failed");
    end
    $finish;
  end

endmodule
